// ===== sv/length_prefix_deframer_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Check cons in the same cycle as ante.
`define LPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define LPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lpd_pkg.sv =====
// Types and constants of the length-prefix deframer.
package lpd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 32;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned HDR_CNT_W = 2;
   localparam int unsigned HDR_BYTES = 4;

   localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX = HDR_CNT_W'(HDR_BYTES - 1);
   localparam logic [LEN_W-1:0]     MAX_LEN_RESET = LEN_W'(1048576);

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_DATA  = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_EMPTY = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_LIMIT = KIND_W'(2);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_CLOSED  = 3'b100
   } phase_type;

endpackage

// ===== sv/length_prefix_deframer.sv =====
// Top level of the length-prefix deframer: 32-bit big-endian header, byte payload.
// Path: input register, then framing logic, then the output (result) register.
// Throughput: one byte per cycle while results are taken; the header/length counter
// update between the input register and the result register is combinational.
// Reset (synchronous, active high): back to header phase with counters cleared,
// maximum length back to 1048576; a closed channel reopens only through reset.
module length_prefix_deframer (
   input  logic        clock,
   input  logic        reset,
   // Configuration: maximum payload length
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   // Received bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   output logic        rsp_tlast    // out_last
);

   `include "length_prefix_deframer_macros.svh"

   // Configuration register
   logic [lpd_pkg::LEN_W-1:0] max_len_ff;

   // Input stage
   logic                       in_valid_ff;
   logic [lpd_pkg::BYTE_W-1:0] in_byte_ff;

   // Framing state
   lpd_pkg::phase_type            phase_ff, phase_in;
   logic [lpd_pkg::HDR_CNT_W-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [lpd_pkg::LEN_W-1:0]     len_ff, len_in;

   // Result register
   logic                       out_valid_ff, out_valid_in;
   logic [lpd_pkg::KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [lpd_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;

   logic                       out_free;
   logic                       step;
   logic [lpd_pkg::LEN_W-1:0]  hdr_len;
   logic                       res_valid;

   // The result register can take a new value when empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   // The buffered byte is processed whenever the result register can follow.
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   // Shift the new byte in below the bytes gathered so far (most significant first).
   assign hdr_len = {len_ff[lpd_pkg::LEN_W-lpd_pkg::BYTE_W-1:0], in_byte_ff};

   always_comb begin
      phase_in    = phase_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      len_in      = len_ff;
      res_valid   = 1'b0;
      out_kind_in = lpd_pkg::KIND_DATA;
      out_byte_in = '0;
      out_last_in = 1'b0;
      case (phase_ff)
         lpd_pkg::PH_HEADER: begin
            len_in = hdr_len;
            if (hdr_cnt_ff != lpd_pkg::HDR_LAST_IDX) begin
               // Still gathering the header: no result.
               hdr_cnt_in = hdr_cnt_ff + 1'b1;
            end else begin
               hdr_cnt_in = '0;
               res_valid  = 1'b0;
               if (hdr_len > max_len_ff) begin
                  // Oversized frame: report once and close until reset.
                  len_in      = '0;
                  phase_in    = lpd_pkg::PH_CLOSED;
                  res_valid   = 1'b1;
                  out_kind_in = lpd_pkg::KIND_LIMIT;
               end else if (hdr_len == '0) begin
                  res_valid   = 1'b1;
                  out_kind_in = lpd_pkg::KIND_EMPTY;
                  out_last_in = 1'b1;
               end else begin
                  phase_in = lpd_pkg::PH_PAYLOAD;
               end
            end
         end
         lpd_pkg::PH_PAYLOAD: begin
            // Forward the byte and count down what is left of the frame.
            len_in      = len_ff - 1'b1;
            res_valid   = 1'b1;
            out_kind_in = lpd_pkg::KIND_DATA;
            out_byte_in = in_byte_ff;
            out_last_in = (len_ff == lpd_pkg::LEN_W'(1));
            if (len_ff == lpd_pkg::LEN_W'(1)) begin
               phase_in = lpd_pkg::PH_HEADER;
            end
         end
         default: begin
            // Closed: drop every byte.
            res_valid = 1'b0;
         end
      endcase
   end

   // Load the result register with this step's result, or empty it once taken.
   assign out_valid_in = out_free ? (step && res_valid) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= lpd_pkg::MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lpd_pkg::PH_HEADER;
         hdr_cnt_ff <= '0;
         len_ff     <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         len_ff     <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         out_kind_ff <= out_kind_in;
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
      end
   end

   `LPD_ASSERT_NEXT(a_closed_sticky, phase_ff == lpd_pkg::PH_CLOSED, phase_ff == lpd_pkg::PH_CLOSED, "closed channel reopened without reset")
   `LPD_ASSERT_NOW(a_hdr_cnt_phase, hdr_cnt_ff != '0, phase_ff == lpd_pkg::PH_HEADER, "header count set outside header phase")
   `LPD_ASSERT_NOW(a_payload_len, phase_ff == lpd_pkg::PH_PAYLOAD, len_ff != '0, "payload phase with nothing left to forward")
   `LPD_ASSERT_NOW(a_limit_fields, rsp_tvalid && (rsp_tuser == lpd_pkg::KIND_LIMIT), !rsp_tlast && (rsp_tdata == '0), "limit result carries data or last")
   `LPD_ASSERT_NOW(a_ready_when_free, out_free, req_tready, "input stalled while result register free")

endmodule
